@@ src/json_string_unescape_macros.svh @@
// Assertion macros for the string unescape block; jsu_decode is the file that uses them.
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// Implication within the same cycle, checked outside reset.
`define JSU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, checked outside reset.
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/jsu_pkg.sv @@
package jsu_pkg;

   typedef enum logic [1:0] {
      MODE_PLAIN  = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_HEX    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } item_type;

   typedef struct packed {
      logic [15:0] code_point;
      kind_type    kind;
   } result_type;

   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_FF        = 8'h0C;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [1:0] HEX_LAST_DIGIT = 2'd3;

   // Bit 4 set means the byte is not a hex digit; bits 3:0 hold the digit.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [7:0] diff;
      logic [4:0] res;
      diff = 8'd0;
      res  = 5'h10;
      if (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9) begin
         diff = b - CHAR_DIGIT_0;
         res  = {1'b0, diff[3:0]};
      end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) begin
         diff = b - CHAR_LOWER_A + 8'd10;
         res  = {1'b0, diff[3:0]};
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         diff = b - CHAR_UPPER_A + 8'd10;
         res  = {1'b0, diff[3:0]};
      end
      return res;
   endfunction

   function automatic logic [7:0] escape_map(input logic [7:0] b);
      logic [7:0] res;
      unique case (b)
         CHAR_LOWER_B: res = CHAR_BS;
         CHAR_LOWER_F: res = CHAR_FF;
         CHAR_LOWER_N: res = CHAR_LF;
         CHAR_LOWER_R: res = CHAR_CR;
         CHAR_LOWER_T: res = CHAR_TAB;
         default:      res = b;
      endcase
      return res;
   endfunction

endpackage

@@ src/jsu_in_reg.sv @@
module jsu_in_reg
   import jsu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  item_type req_item,
   output logic     req_ready,
   input  logic     take,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // The register may refill in the same cycle that its content moves on.
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ src/jsu_decode.sv @@
`include "json_string_unescape_macros.svh"

module jsu_decode
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   input  logic       out_free,
   output logic       take,
   output logic       result_valid,
   output result_type result
);

   mode_type    mode_ff;
   mode_type    mode_in;
   logic [1:0]  cnt_ff;
   logic [1:0]  cnt_in;
   logic [11:0] acc_ff;
   logic [11:0] acc_in;
   logic        has_result;
   logic [4:0]  hex;

   // An item moves on whenever the result register can take a result.
   assign take         = item_valid && out_free;
   assign result_valid = take && has_result;
   assign hex          = hex_value(item.in_byte);

   always_comb begin
      mode_in           = mode_ff;
      cnt_in            = cnt_ff;
      acc_in            = acc_ff;
      has_result        = 1'b0;
      result.code_point = 16'd0;
      result.kind       = KIND_CHAR;
      if (item.end_of_input) begin
         has_result  = 1'b1;
         result.kind = KIND_ERROR;
         mode_in     = MODE_PLAIN;
         cnt_in      = 2'd0;
         acc_in      = 12'd0;
      end else begin
         unique case (mode_ff)
            MODE_ESCAPE: begin
               if (item.in_byte == CHAR_LOWER_U) begin
                  mode_in = MODE_HEX;
                  cnt_in  = 2'd0;
                  acc_in  = 12'd0;
               end else begin
                  mode_in           = MODE_PLAIN;
                  has_result        = 1'b1;
                  result.code_point = {8'd0, escape_map(item.in_byte)};
               end
            end
            MODE_HEX: begin
               if (hex[4]) begin
                  has_result  = 1'b1;
                  result.kind = KIND_ERROR;
                  mode_in     = MODE_PLAIN;
                  cnt_in      = 2'd0;
                  acc_in      = 12'd0;
               end else if (cnt_ff == HEX_LAST_DIGIT) begin
                  has_result        = 1'b1;
                  result.code_point = {acc_ff, hex[3:0]};
                  mode_in           = MODE_PLAIN;
                  cnt_in            = 2'd0;
                  acc_in            = 12'd0;
               end else begin
                  acc_in = {acc_ff[7:0], hex[3:0]};
                  cnt_in = cnt_ff + 2'd1;
               end
            end
            default: begin
               mode_in = MODE_PLAIN;
               if (item.in_byte < CHAR_SPACE) begin
                  has_result  = 1'b1;
                  result.kind = KIND_ERROR;
               end else if (item.in_byte == CHAR_QUOTE) begin
                  has_result  = 1'b1;
                  result.kind = KIND_END;
               end else if (item.in_byte == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  has_result        = 1'b1;
                  result.code_point = {8'd0, item.in_byte};
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         cnt_ff  <= 2'd0;
         acc_ff  <= 12'd0;
      end else if (take) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
      end
   end

   `JSU_ASSERT_NEXT(a_clear_after_end, clock, reset, result_valid && result.kind != KIND_CHAR, mode_ff == MODE_PLAIN && cnt_ff == 2'd0 && acc_ff == 12'd0, "state not cleared after end or error")
   `JSU_ASSERT_SAME(a_count_only_hex, clock, reset, cnt_ff != 2'd0, mode_ff == MODE_HEX, "hex digit count outside hex mode")
   `JSU_ASSERT_SAME(a_zero_on_status, clock, reset, result_valid && result.kind != KIND_CHAR, result.code_point == 16'd0, "code point not zero on end or error")

endmodule

@@ src/jsu_out_reg.sv @@
module jsu_out_reg
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       out_free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

@@ src/json_string_unescape.sv @@
// Channel   Direction  Ports                                   Content
// req       in         req_valid req_ready req_in_byte ...     one byte of a string body
// rsp       out        rsp_valid rsp_ready rsp_code_point ...  one code point or a status
//
// One byte is taken per cycle, sustained while rsp_ready stays high. A transaction is held
// in the input register and its result in the result register, the two around the decoder.
// Bytes that open an escape, the u that opens a hex escape, or hex digits one to three give no result.
// Reset is synchronous and active high; it empties both registers and returns to plain mode.
// When the result register holds and rsp_ready is low, req_ready falls once the
// input register is also full; nothing is lost or repeated.
module json_string_unescape
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_point,
   output logic [1:0]  rsp_kind
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       take;
   logic       out_free;
   logic       result_valid;
   result_type result;
   result_type rsp_result;

   // Pack the request fields into one item for the input register.
   assign req_item.in_byte      = req_in_byte;
   assign req_item.end_of_input = req_end_of_input;

   // The input register holds one transaction until the decoder takes it.
   jsu_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_ready  (req_ready),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // The decoder keeps the escape state and works out the result in one step.
   jsu_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .out_free     (out_free),
      .take         (take),
      .result_valid (result_valid),
      .result       (result)
   );

   // The result register parts the decoder from the consumer of results.
   jsu_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (result_valid),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_code_point = rsp_result.code_point;
   assign rsp_kind       = rsp_result.kind;

endmodule
